// ===== rtl/core/dpw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and rounding helper of the depth pixel to world point unit.
// Depends on nothing.
package dpw_pkg;

  localparam int CFG_INDEX_W = 4;
  localparam int MID_DEPTH   = 8;
  localparam int OUT_DEPTH   = 16;
  localparam int DIM_W       = 15;

  localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_FORMAT    = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_SCALE_INV = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FOCAL_INV       = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PRINCIPAL       = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ROT_X           = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ROT_Y           = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_ROT_Z           = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_TRANSLATION     = 4'd7;

  localparam logic [56:0] NEAR_LIMIT_Q16 = 57'd6553;
  localparam logic [56:0] FAR_LIMIT_Q16  = 57'd393216;
  localparam logic [7:0]  EXP_LOW_LIMIT  = 8'd104;
  localparam logic [7:0]  EXP_FAR        = 8'd164;
  localparam logic [7:0]  EXP_SHIFT_BASE = 8'd163;
  localparam logic [5:0]  INT_SHIFT_M1   = 6'd13;

  typedef struct packed {
    logic        format;
    logic [31:0] scale;
    logic [15:0] cx;
    logic [15:0] cy;
  } dpw_front_cfg_t;

  typedef struct packed {
    logic [31:0] fx_inv;
    logic [31:0] fy_inv;
    logic [47:0] row_x;
    logic [47:0] row_y;
    logic [47:0] row_z;
    logic [59:0] trans;
  } dpw_back_cfg_t;

  typedef struct packed {
    logic [18:0]        depth;
    logic signed [16:0] du;
    logic signed [16:0] dv;
    logic [23:0]        color;
  } dpw_mid_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [23:0] color;
  } dpw_point_t;

  function automatic logic signed [65:0] round_half_away(input logic signed [65:0] value,
                                                         input int unsigned shift);
    logic [65:0] mag;
    logic [65:0] half;
    half = 66'(1) << (shift - 1);
    mag  = value[65] ? 66'(-value) : 66'(value);
    mag  = (mag + half) >> shift;
    return value[65] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

// ===== rtl/core/dpw_queue.sv =====
`timescale 1ns / 1ps
// Small first-in first-out queue of packed entries.
// Depends on nothing.
module dpw_queue #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic                       empty
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end

  assign pop_data = mem[rd_ptr];
  assign empty    = (count == '0);
endmodule

// ===== rtl/core/dpw_front.sv =====
`timescale 1ns / 1ps
// Front part: takes pixels, subsample and image checks, depth scaling and range test.
// Depends on dpw_pkg.
module dpw_front #(
  parameter int SUBSAMPLE_STEP = 4,
  parameter int MAX_IMAGE_DIM  = 4096
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    take,
  input  logic [11:0]             column,
  input  logic [11:0]             pixel_row,
  input  logic [31:0]             depth_raw,
  input  logic [23:0]             color,
  input  dpw_pkg::dpw_front_cfg_t cfg,
  output logic                    mid_push,
  output dpw_pkg::dpw_mid_t       mid_data,
  output logic [1:0]              busy_count
);
  import dpw_pkg::*;

  localparam int DIV_SHIFT = 24;
  localparam logic [24:0] RECIP = 25'((2**DIV_SHIFT + SUBSAMPLE_STEP - 1) / SUBSAMPLE_STEP);

  logic        f0_valid;
  logic [11:0] f0_u, f0_v;
  logic [31:0] f0_raw;
  logic [23:0] f0_color;

  logic        f1_valid, f1_ok, f1_drop;
  logic [5:0]  f1_shift;
  logic [55:0] f1_p;
  logic [11:0] f1_u, f1_v;
  logic [23:0] f1_color;

  logic        f2_valid;
  dpw_mid_t    f2_data;

  logic [36:0] prod_u, prod_v;
  logic [15:0] back_u, back_v;
  logic        in_image, on_grid;
  logic [7:0]  exp_field;
  logic [23:0] mant;
  logic [55:0] q;
  logic [56:0] d_full;
  logic        keep;

  always_comb begin
    prod_u    = 37'(f0_u) * 37'(RECIP);
    prod_v    = 37'(f0_v) * 37'(RECIP);
    back_u    = 16'(prod_u[DIV_SHIFT +: 12]) * 16'(SUBSAMPLE_STEP);
    back_v    = 16'(prod_v[DIV_SHIFT +: 12]) * 16'(SUBSAMPLE_STEP);
    on_grid   = (back_u == 16'(f0_u)) && (back_v == 16'(f0_v));
    in_image  = (DIM_W'(f0_u) < DIM_W'(MAX_IMAGE_DIM)) && (DIM_W'(f0_v) < DIM_W'(MAX_IMAGE_DIM));
    exp_field = f0_raw[30:23];
    mant      = cfg.format ? {1'b1, f0_raw[22:0]} : {8'b0, f0_raw[15:0]};
  end

  always_comb begin
    q      = f1_p >> f1_shift;
    d_full = (57'(q) + 57'd1) >> 1;
    keep   = f1_ok && !f1_drop && (d_full > NEAR_LIMIT_Q16) && (d_full <= FAR_LIMIT_Q16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f0_valid <= 1'b0;
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else begin
      f0_valid <= take;
      f1_valid <= f0_valid;
      f2_valid <= f1_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    f0_u     <= column;
    f0_v     <= pixel_row;
    f0_raw   <= depth_raw;
    f0_color <= color;

    f1_ok    <= in_image && on_grid;
    f1_drop  <= cfg.format && (exp_field == 8'hFF || f0_raw[31] ||
                exp_field < EXP_LOW_LIMIT || exp_field >= EXP_FAR);
    f1_shift <= cfg.format ? 6'(EXP_SHIFT_BASE - exp_field) : INT_SHIFT_M1;
    f1_p     <= 56'(mant) * 56'(cfg.scale);
    f1_u     <= f0_u;
    f1_v     <= f0_v;
    f1_color <= f0_color;

    f2_data.depth <= d_full[18:0];
    f2_data.du    <= $signed({1'b0, f1_u, 4'b0}) - $signed({1'b0, cfg.cx});
    f2_data.dv    <= $signed({1'b0, f1_v, 4'b0}) - $signed({1'b0, cfg.cy});
    f2_data.color <= f1_color;
  end

  assign mid_push   = f2_valid;
  assign mid_data   = f2_data;
  assign busy_count = 2'(f0_valid) + 2'(f1_valid) + 2'(f2_valid);
endmodule

// ===== rtl/core/dpw_back.sv =====
`timescale 1ns / 1ps
// Back part: pinhole back-projection, rotation, translation, rounding and saturation.
// Depends on dpw_pkg.
module dpw_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           mid_empty,
  input  dpw_pkg::dpw_mid_t              mid_data,
  input  logic [$clog2(dpw_pkg::OUT_DEPTH+1)-1:0] out_count,
  input  dpw_pkg::dpw_back_cfg_t         cfg,
  output logic                           mid_pop,
  output logic                           out_push,
  output dpw_pkg::dpw_point_t            out_data
);
  import dpw_pkg::*;

  localparam int CW = $clog2(OUT_DEPTH + 1);

  logic [6:0] vld;

  logic signed [36:0] b1_mx, b1_my;
  logic [18:0]        b1_d, b2_d, b3_d;
  logic [23:0]        b1_c, b2_c, b3_c, b4_c, b5_c, b6_c, b7_c;
  logic signed [32:0] b2_rx, b2_ry;
  logic signed [65:0] b3_xx, b3_yy;
  logic signed [33:0] b4_pc [3];
  logic signed [49:0] b5_prod [3][3];
  logic signed [53:0] b6_sum [3];
  logic [31:0]        b7_w [3];

  logic signed [65:0] rx_full, ry_full, px_full, py_full;
  logic signed [65:0] rw_full [3];
  logic [47:0]        rows [3];
  logic signed [19:0] trans_i [3];
  logic [2:0]         busy;

  always_comb begin
    busy    = 3'(vld[0]) + 3'(vld[1]) + 3'(vld[2]) + 3'(vld[3]) + 3'(vld[4]) +
              3'(vld[5]) + 3'(vld[6]);
    mid_pop = !mid_empty && ((CW'(out_count) + CW'(busy)) < CW'(OUT_DEPTH));
    rx_full = round_half_away(66'(b1_mx), 4);
    ry_full = round_half_away(66'(b1_my), 4);
    px_full = round_half_away(b3_xx, 32);
    py_full = round_half_away(b3_yy, 32);
    rows[0] = cfg.row_x;
    rows[1] = cfg.row_y;
    rows[2] = cfg.row_z;
    trans_i[0] = $signed(cfg.trans[59:40]);
    trans_i[1] = $signed(cfg.trans[39:20]);
    trans_i[2] = $signed(cfg.trans[19:0]);
    for (int i = 0; i < 3; i++) begin
      rw_full[i] = round_half_away(66'(b6_sum[i]), 14);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[5:0], mid_pop};
    end
  end

  always_ff @(posedge clk) begin
    b1_mx <= mid_data.du * $signed({1'b0, mid_data.depth});
    b1_my <= mid_data.dv * $signed({1'b0, mid_data.depth});
    b1_d  <= mid_data.depth;
    b1_c  <= mid_data.color;

    b2_rx <= rx_full[32:0];
    b2_ry <= ry_full[32:0];
    b2_d  <= b1_d;
    b2_c  <= b1_c;

    b3_xx <= b2_rx * $signed({1'b0, cfg.fx_inv});
    b3_yy <= b2_ry * $signed({1'b0, cfg.fy_inv});
    b3_d  <= b2_d;
    b3_c  <= b2_c;

    b4_pc[0] <= px_full[33:0];
    b4_pc[1] <= py_full[33:0];
    b4_pc[2] <= $signed({15'b0, b3_d});
    b4_c     <= b3_c;

    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        b5_prod[i][j] <= $signed(rows[i][47 - 16*j -: 16]) * b4_pc[j];
      end
    end
    b5_c <= b4_c;

    for (int i = 0; i < 3; i++) begin
      b6_sum[i] <= 54'(b5_prod[i][0]) + 54'(b5_prod[i][1]) + 54'(b5_prod[i][2]) +
                   (54'(trans_i[i]) <<< 22);
    end
    b6_c <= b5_c;

    for (int i = 0; i < 3; i++) begin
      if (rw_full[i] > 66'sd2147483647) begin
        b7_w[i] <= 32'h7FFF_FFFF;
      end else if (rw_full[i] < -66'sd2147483648) begin
        b7_w[i] <= 32'h8000_0000;
      end else begin
        b7_w[i] <= rw_full[i][31:0];
      end
    end
    b7_c <= b6_c;
  end

  assign out_push       = vld[6];
  assign out_data.x     = b7_w[0];
  assign out_data.y     = b7_w[1];
  assign out_data.z     = b7_w[2];
  assign out_data.color = b7_c;
endmodule

// ===== rtl/core/depth_pixel_to_world_point_unit.sv =====
`timescale 1ns / 1ps
// Top level of the depth pixel to world point unit: registers, queues, front and back.
// Depends on dpw_pkg, dpw_queue, dpw_front, dpw_back.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------
//  pixel in | push / full        | column, pixel_row, depth_raw, red, green, blue
//  point out| empty / pop        | world_x, world_y, world_z, packed_color
//  config   | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One pixel per cycle is taken while the queues have room.
// A pixel passes the input register, 2 front stages after it, the middle queue, 7 back stages
// and the result queue before it reaches the ports.
// Reset clears all control state and loads the register reset values.
// A full result queue stalls the back part; the middle queue then stalls the input.
module depth_pixel_to_world_point_unit #(
  parameter int SUBSAMPLE_STEP = 4,
  parameter int MAX_IMAGE_DIM  = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [11:0]                     column,
  input  logic [11:0]                     pixel_row,
  input  logic [31:0]                     depth_raw,
  input  logic [7:0]                      red,
  input  logic [7:0]                      green,
  input  logic [7:0]                      blue,
  output logic                            empty,
  input  logic                            pop,
  output logic signed [31:0]              world_x,
  output logic signed [31:0]              world_y,
  output logic signed [31:0]              world_z,
  output logic [23:0]                     packed_color,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dpw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data
);
  import dpw_pkg::*;

  localparam int MW = $bits(dpw_mid_t);
  localparam int PW = $bits(dpw_point_t);

  logic        depth_format;
  logic [31:0] depth_scale_inverse;
  logic [63:0] focal_inverse;
  logic [31:0] principal_point;
  logic [47:0] rotation_row_x, rotation_row_y, rotation_row_z;
  logic [59:0] translation;

  dpw_front_cfg_t front_cfg;
  dpw_back_cfg_t  back_cfg;

  logic                             take;
  logic                             mid_push, mid_pop, mid_empty;
  dpw_mid_t                         mid_in, mid_out;
  logic [$clog2(MID_DEPTH+1)-1:0]   mid_count;
  logic [1:0]                       front_busy;
  logic                             out_push;
  dpw_point_t                       out_in, out_head;
  logic [$clog2(OUT_DEPTH+1)-1:0]   out_count;
  logic                             out_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_format        <= 1'b0;
      depth_scale_inverse <= 32'h4000_0000;
      focal_inverse       <= '0;
      principal_point     <= '0;
      rotation_row_x      <= 48'h4000_0000_0000;
      rotation_row_y      <= 48'h0000_4000_0000;
      rotation_row_z      <= 48'h0000_0000_4000;
      translation         <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEPTH_FORMAT:    depth_format        <= cfg_data[0];
        REG_DEPTH_SCALE_INV: depth_scale_inverse <= cfg_data[31:0];
        REG_FOCAL_INV:       focal_inverse       <= cfg_data;
        REG_PRINCIPAL:       principal_point     <= cfg_data[31:0];
        REG_ROT_X:           rotation_row_x      <= cfg_data[47:0];
        REG_ROT_Y:           rotation_row_y      <= cfg_data[47:0];
        REG_ROT_Z:           rotation_row_z      <= cfg_data[47:0];
        REG_TRANSLATION:     translation         <= cfg_data[59:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    front_cfg.format = depth_format;
    front_cfg.scale  = depth_scale_inverse;
    front_cfg.cx     = principal_point[31:16];
    front_cfg.cy     = principal_point[15:0];
    back_cfg.fx_inv  = focal_inverse[63:32];
    back_cfg.fy_inv  = focal_inverse[31:0];
    back_cfg.row_x   = rotation_row_x;
    back_cfg.row_y   = rotation_row_y;
    back_cfg.row_z   = rotation_row_z;
    back_cfg.trans   = translation;
  end

  assign full = (5'(mid_count) + 5'(front_busy)) >= 5'(MID_DEPTH);
  assign take = push && !full;

  dpw_front #(
    .SUBSAMPLE_STEP(SUBSAMPLE_STEP),
    .MAX_IMAGE_DIM (MAX_IMAGE_DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .column    (column),
    .pixel_row (pixel_row),
    .depth_raw (depth_raw),
    .color     ({red, green, blue}),
    .cfg       (front_cfg),
    .mid_push  (mid_push),
    .mid_data  (mid_in),
    .busy_count(front_busy)
  );

  dpw_queue #(
    .DEPTH(MID_DEPTH),
    .WIDTH(MW)
  ) u_mid_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (mid_push),
    .push_data(mid_in),
    .pop      (mid_pop),
    .pop_data (mid_out),
    .count    (mid_count),
    .empty    (mid_empty)
  );

  dpw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .mid_empty(mid_empty),
    .mid_data (mid_out),
    .out_count(out_count),
    .cfg      (back_cfg),
    .mid_pop  (mid_pop),
    .out_push (out_push),
    .out_data (out_in)
  );

  assign out_pop = pop && !empty;

  dpw_queue #(
    .DEPTH(OUT_DEPTH),
    .WIDTH(PW)
  ) u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (out_push),
    .push_data(out_in),
    .pop      (out_pop),
    .pop_data (out_head),
    .count    (out_count),
    .empty    (empty)
  );

  assign world_x      = $signed(out_head.x);
  assign world_y      = $signed(out_head.y);
  assign world_z      = $signed(out_head.z);
  assign packed_color = out_head.color;
endmodule

// ===== rtl/core/dpw_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the depth pixel to world point unit, bound to the top level.
// Depends on depth_pixel_to_world_point_unit.
module dpw_checker (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic signed [31:0] world_x,
  input logic signed [31:0] world_y,
  input logic signed [31:0] world_z,
  input logic [23:0]        packed_color
);
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_reset_not_full: assert property (@(posedge clk) rst |=> !full)
    else $error("input full after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty)
    else $error("waiting result vanished");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> $stable(world_x) && $stable(world_y) && $stable(world_z) &&
                       $stable(packed_color))
    else $error("waiting result changed");
endmodule

bind depth_pixel_to_world_point_unit dpw_checker u_dpw_checker (.*);

// ===== tb/tb_depth_pixel_to_world_point_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of depth_pixel_to_world_point_unit: directed pixel table,
// then random pixel phases under several register settings and idle patterns.
// Depends on dpw_pkg and the unit's RTL.
module tb_depth_pixel_to_world_point_unit;
  import dpw_pkg::*;

  localparam int STEP        = 4;
  localparam int WATCH_LIMIT = 20000;
  localparam int DRAIN_WAIT  = 14;

  typedef logic signed [127:0] wide_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_POINT, CHK_DROP} row_check_t;

  typedef struct packed {
    logic        fmt;
    logic [11:0] u;
    logic [11:0] v;
    logic [31:0] raw;
    logic [23:0] color;
    row_check_t  check;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } pixel_row_t;

  localparam int N_ROWS = 20;
  pixel_row_t pixel_table [N_ROWS] = '{
    '{1'b0, 12'd0,    12'd0,    32'd3,          24'h123456, CHK_POINT, 32'd0, 32'd0, 32'd196608},
    '{1'b0, 12'd4,    12'd8,    32'd6,          24'hFFFFFF, CHK_POINT, 32'd0, 32'd0, 32'd393216},
    '{1'b0, 12'd4092, 12'd4092, 32'd1,          24'h000000, CHK_POINT, 32'd0, 32'd0, 32'd65536},
    '{1'b0, 12'd0,    12'd0,    32'hFFFF0002,   24'hA5A5A5, CHK_POINT, 32'd0, 32'd0, 32'd131072},
    '{1'b0, 12'd0,    12'd0,    32'd7,          24'h5A5A5A, CHK_DROP,  32'd0, 32'd0, 32'd0},
    '{1'b0, 12'd0,    12'd0,    32'd0,          24'h010203, CHK_DROP,  32'd0, 32'd0, 32'd0},
    '{1'b0, 12'd1,    12'd0,    32'd3,          24'h0F0F0F, CHK_DROP,  32'd0, 32'd0, 32'd0},
    '{1'b0, 12'd0,    12'd2,    32'd3,          24'hF0F0F0, CHK_DROP,  32'd0, 32'd0, 32'd0},
    '{1'b0, 12'd4095, 12'd4095, 32'hFFFFFFFF,   24'hFFFFFF, CHK_DROP,  32'd0, 32'd0, 32'd0},
    '{1'b0, 12'd4092, 12'd0,    32'h0000FFFF,   24'h800080, CHK_DROP,  32'd0, 32'd0, 32'd0},
    '{1'b1, 12'd0,    12'd0,    32'h3F800000,   24'h112233, CHK_POINT, 32'd0, 32'd0, 32'd65536},
    '{1'b1, 12'd8,    12'd4,    32'h40C00000,   24'h445566, CHK_POINT, 32'd0, 32'd0, 32'd393216},
    '{1'b1, 12'd0,    12'd0,    32'h7FC00000,   24'h778899, CHK_DROP,  32'd0, 32'd0, 32'd0},
    '{1'b1, 12'd0,    12'd0,    32'h7F800000,   24'h778899, CHK_DROP,  32'd0, 32'd0, 32'd0},
    '{1'b1, 12'd0,    12'd0,    32'hBF800000,   24'h778899, CHK_DROP,  32'd0, 32'd0, 32'd0},
    '{1'b1, 12'd0,    12'd0,    32'h00000000,   24'h778899, CHK_DROP,  32'd0, 32'd0, 32'd0},
    '{1'b1, 12'd0,    12'd0,    32'h00000001,   24'h778899, CHK_DROP,  32'd0, 32'd0, 32'd0},
    '{1'b1, 12'd0,    12'd0,    32'h7F7FFFFF,   24'h778899, CHK_DROP,  32'd0, 32'd0, 32'd0},
    '{1'b1, 12'd0,    12'd0,    32'h40D00000,   24'h778899, CHK_DROP,  32'd0, 32'd0, 32'd0},
    '{1'b1, 12'd12,   12'd16,   32'h3DCCCCCD,   24'hABCDEF, CHK_MODEL, 32'd0, 32'd0, 32'd0}
  };

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [11:0] column;
  logic [11:0] pixel_row;
  logic [31:0] depth_raw;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        empty;
  logic        pop;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;
  logic signed [31:0] world_z;
  logic [23:0] packed_color;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [63:0] cfg_data;

  // shadow copy of the register file
  logic        sh_fmt;
  logic [31:0] sh_scale;
  logic [31:0] sh_fx;
  logic [31:0] sh_fy;
  logic [15:0] sh_cx;
  logic [15:0] sh_cy;
  logic [47:0] sh_rx;
  logic [47:0] sh_ry;
  logic [47:0] sh_rz;
  logic [59:0] sh_t;

  dpw_point_t pending_points [$];
  int errors;
  int pixels_sent;
  int points_checked;
  int send_idle_pct;
  int recv_stall_pct;
  int idle_cycles;

  depth_pixel_to_world_point_unit i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .column(column), .pixel_row(pixel_row), .depth_raw(depth_raw),
    .red(red), .green(green), .blue(blue),
    .empty(empty), .pop(pop),
    .world_x(world_x), .world_y(world_y), .world_z(world_z),
    .packed_color(packed_color),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic wide_t round_away(input wide_t value, input int sh);
    wide_t mag;
    mag = (value < 0) ? -value : value;
    mag = (mag + (wide_t'(1) << (sh - 1))) >>> sh;
    return (value < 0) ? -mag : mag;
  endfunction

  function automatic logic [31:0] sat_coord(input wide_t value);
    if (value > 64'sd2147483647) return 32'h7FFFFFFF;
    if (value < -64'sd2147483648) return 32'h80000000;
    return value[31:0];
  endfunction

  function automatic logic [31:0] rotate_translate(input logic [47:0] rot_row,
                                                   input wide_t px, input wide_t py,
                                                   input wide_t pz, input logic [19:0] t);
    wide_t acc;
    acc = wide_t'($signed(rot_row[47:32])) * px + wide_t'($signed(rot_row[31:16])) * py
        + wide_t'($signed(rot_row[15:0])) * pz + (wide_t'($signed(t)) <<< 22);
    return sat_coord(round_away(acc, 14));
  endfunction

  function automatic logic [63:0] depth_to_q16(input logic [31:0] raw, output bit invalid);
    logic [63:0] prod;
    int          sh;
    invalid = 1'b0;
    if (!sh_fmt) return ({48'd0, raw[15:0]} * {32'd0, sh_scale} + 64'd8192) >> 14;
    if (raw[30:23] == 8'hFF) begin
      invalid = 1'b1;
      return 64'd0;
    end
    if (raw[31] || raw[30:23] == 8'd0) return 64'd0;
    prod = {40'd0, 1'b1, raw[22:0]} * {32'd0, sh_scale};
    sh = 164 - int'(raw[30:23]);
    if (prod == 64'd0) return 64'd0;
    if (sh <= 0) return 64'(FAR_LIMIT_Q16) + 64'd1;
    if (sh > 60) return 64'd0;
    return (prod + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic bit project_pixel(input logic [11:0] u, input logic [11:0] v,
                                       input logic [31:0] raw, input logic [23:0] color,
                                       output dpw_point_t pt);
    logic [63:0] depth;
    bit          invalid;
    wide_t       du;
    wide_t       dv;
    wide_t       px;
    wide_t       py;
    wide_t       pz;
    pt = '0;
    if (u % STEP != 0 || v % STEP != 0) return 1'b0;
    depth = depth_to_q16(raw, invalid);
    if (invalid || depth <= 64'(NEAR_LIMIT_Q16) || depth > 64'(FAR_LIMIT_Q16)) return 1'b0;
    du = wide_t'({u, 4'd0}) - wide_t'(sh_cx);
    dv = wide_t'({v, 4'd0}) - wide_t'(sh_cy);
    pz = wide_t'(depth);
    px = round_away(round_away(du * pz, 4) * wide_t'(sh_fx), 32);
    py = round_away(round_away(dv * pz, 4) * wide_t'(sh_fy), 32);
    pt.x = rotate_translate(sh_rx, px, py, pz, sh_t[59:40]);
    pt.y = rotate_translate(sh_ry, px, py, pz, sh_t[39:20]);
    pt.z = rotate_translate(sh_rz, px, py, pz, sh_t[19:0]);
    pt.color = color;
    return 1'b1;
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DEPTH_FORMAT:    sh_fmt = data[0];
      REG_DEPTH_SCALE_INV: sh_scale = data[31:0];
      REG_FOCAL_INV: begin
        sh_fx = data[63:32];
        sh_fy = data[31:0];
      end
      REG_PRINCIPAL: begin
        sh_cx = data[31:16];
        sh_cy = data[15:0];
      end
      REG_ROT_X:       sh_rx = data[47:0];
      REG_ROT_Y:       sh_ry = data[47:0];
      REG_ROT_Z:       sh_rz = data[47:0];
      REG_TRANSLATION: sh_t = data[59:0];
      default: ;
    endcase
  endtask

  // hold the sender until every expected point is out, then let the pipe settle
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic send_pixel(input logic [11:0] u, input logic [11:0] v,
                            input logic [31:0] raw, input logic [23:0] color,
                            input row_check_t check, input dpw_point_t typed);
    dpw_point_t pt;
    push      <= 1'b1;
    column    <= u;
    pixel_row <= v;
    depth_raw <= raw;
    red       <= color[23:16];
    green     <= color[15:8];
    blue      <= color[7:0];
    do @(posedge clk); while (full);
    pixels_sent++;
    case (check)
      CHK_POINT: pending_points.insert(pending_points.size(), typed);
      CHK_MODEL: if (project_pixel(u, v, raw, color, pt))
                   pending_points.insert(pending_points.size(), pt);
      default: ;
    endcase
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic configure(input int profile);
    logic [63:0] vals [8];
    case (profile)
      0, 1, 7: begin
        vals[0] = (profile == 0) ? 64'd0 : 64'd1;
        vals[1] = (profile == 0) ? 64'd1073742 : 64'd1073741824;
        vals[2] = {32'd8181000 + $urandom_range(50000), 32'd8181000 + $urandom_range(50000)};
        vals[3] = {32'd0, 16'd5112, 16'd3832};
        vals[4] = {16'd0, 16'h4000 - 16'($urandom_range(600)), 16'($urandom_range(400)),
                   16'd0};
        vals[5] = {16'd0, 16'($urandom_range(400)), 16'h4000, 16'hFF00};
        vals[6] = {16'd0, 16'd0, 16'd300, 16'h3F00};
        vals[7] = {4'd0, 20'($urandom), 20'($urandom), 20'($urandom)};
      end
      2: begin
        foreach (vals[i]) vals[i] = '1;
        vals[0] = 64'd0;
      end
      3: begin
        foreach (vals[i]) vals[i] = '0;
        vals[2] = {$urandom, $urandom};
      end
      4: begin
        vals[0] = 64'd1;
        for (int i = 1; i < 8; i++) vals[i] = {$urandom, $urandom};
      end
      5: begin
        vals[0] = 64'd0;
        vals[1] = 64'd1073742;
        vals[2] = '1;
        vals[3] = '0;
        vals[4] = {16'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF};
        vals[5] = {16'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF};
        vals[6] = {16'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF};
        vals[7] = {4'd0, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF};
      end
      default: begin
        vals[0] = 64'd0;
        vals[1] = 64'd1073742;
        vals[2] = '1;
        vals[3] = '0;
        vals[4] = {16'd0, 16'h8000, 16'h8000, 16'h8000};
        vals[5] = {16'd0, 16'h8000, 16'h8000, 16'h8000};
        vals[6] = {16'd0, 16'h8000, 16'h8000, 16'h8000};
        vals[7] = {4'd0, 20'h80000, 20'h80000, 20'h80000};
      end
    endcase
    write_reg(REG_DEPTH_FORMAT, vals[0]);
    write_reg(REG_DEPTH_SCALE_INV, vals[1]);
    write_reg(REG_FOCAL_INV, vals[2]);
    write_reg(REG_PRINCIPAL, vals[3]);
    write_reg(REG_ROT_X, vals[4]);
    write_reg(REG_ROT_Y, vals[5]);
    write_reg(REG_ROT_Z, vals[6]);
    write_reg(REG_TRANSLATION, vals[7]);
  endtask

  function automatic logic [31:0] rand_depth();
    int pick;
    pick = $urandom_range(99);
    if (pick >= 80) return $urandom;
    if (!sh_fmt) return (pick < 70) ? 32'($urandom_range(7000)) : 32'($urandom_range(8));
    if (pick < 70) return {1'b0, 8'($urandom_range(129, 119)), 23'($urandom)};
    case ($urandom_range(3))
      0: return 32'h7F800000 | 32'($urandom_range(1));
      1: return {1'b1, 31'($urandom)};
      2: return {9'd0, 23'($urandom)};
      default: return {1'b0, 8'($urandom_range(254, 200)), 23'($urandom)};
    endcase
  endfunction

  // point side: random stalls, compare against the oldest expectation
  initial begin
    dpw_point_t want;
    pop = 1'b0;
    @(negedge rst);
    forever begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
      @(posedge clk);
      if (pop && !empty) begin
        if (pending_points.size() == 0) begin
          report_mismatch("point with no pixel pending");
        end else begin
          want = pending_points.pop_front();
          points_checked++;
          if (world_x !== want.x)
            report_mismatch($sformatf("world_x %0h, want %0h", world_x, want.x));
          if (world_y !== want.y)
            report_mismatch($sformatf("world_y %0h, want %0h", world_y, want.y));
          if (world_z !== want.z)
            report_mismatch($sformatf("world_z %0h, want %0h", world_z, want.z));
          if (packed_color !== want.color)
            report_mismatch($sformatf("packed_color %0h, want %0h", packed_color, want.color));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCH_LIMIT) begin
      $display("FAIL depth_pixel_to_world_point_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dpw_point_t typed;
    int         n_items;
    rst = 1'b1;
    push = 1'b0;
    column = '0;
    pixel_row = '0;
    depth_raw = '0;
    red = '0;
    green = '0;
    blue = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    pixels_sent = 0;
    points_checked = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sh_fmt = 1'b0;
    sh_scale = 32'd1073741824;
    sh_fx = '0;
    sh_fy = '0;
    sh_cx = '0;
    sh_cy = '0;
    sh_rx = 48'h4000_0000_0000;
    sh_ry = 48'h0000_4000_0000;
    sh_rz = 48'h0000_0000_4000;
    sh_t = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (pixel_table[i]) begin
      if (pixel_table[i].fmt != sh_fmt) begin
        drain();
        write_reg(REG_DEPTH_FORMAT, {63'd0, pixel_table[i].fmt});
      end
      typed = '{x: pixel_table[i].x, y: pixel_table[i].y, z: pixel_table[i].z,
                color: pixel_table[i].color};
      send_pixel(pixel_table[i].u, pixel_table[i].v, pixel_table[i].raw,
                 pixel_table[i].color, pixel_table[i].check, typed);
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      configure(ph);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      n_items = (ph == 3) ? 40 : 130;
      repeat (n_items) begin
        if ($urandom_range(3) != 0)
          send_pixel(12'($urandom_range(1023) * STEP), 12'($urandom_range(1023) * STEP),
                     rand_depth(), 24'($urandom), CHK_MODEL, typed);
        else
          send_pixel(12'($urandom), 12'($urandom), rand_depth(), 24'($urandom),
                     CHK_MODEL, typed);
      end
    end
    drain();

    $display("covered %0d pixels, %0d world points checked, across integer and float depth,",
             pixels_sent, points_checked);
    $display("zero, saturating and random registers, with sender and receiver stalls");
    if (errors == 0) begin
      $display("PASS depth_pixel_to_world_point_unit");
    end else begin
      $display("FAIL depth_pixel_to_world_point_unit");
    end
    $finish;
  end

endmodule

// ===== depth_pixel_to_world_point_unit.f =====
rtl/core/dpw_pkg.sv
rtl/core/dpw_queue.sv
rtl/core/dpw_front.sv
rtl/core/dpw_back.sv
rtl/core/depth_pixel_to_world_point_unit.sv
rtl/core/dpw_checker.sv
tb/tb_depth_pixel_to_world_point_unit.sv
